@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/iasc_pkg.sv @@
// Types and constants of the instrument address string checker.
package iasc_pkg;

	localparam int CHAR_W = 8;
	localparam int NUM_W  = 32;

	localparam logic [NUM_W-1:0]  DIGIT_LIMIT = 32'd429496729;
	localparam logic [CHAR_W-1:0] CASE_FOLD   = 8'h20;

	localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
	localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
	localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
	localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	localparam logic [1:0] V_PENDING = 2'd0;
	localparam logic [1:0] V_ACCEPT  = 2'd1;
	localparam logic [1:0] V_REJECT  = 2'd2;

	typedef enum logic [16:0] {
		PH_PFX_T   = 17'h00001,
		PH_PFX_C   = 17'h00002,
		PH_PFX_P1  = 17'h00004,
		PH_PFX_I   = 17'h00008,
		PH_PFX_P2  = 17'h00010,
		PH_BOARD   = 17'h00020,
		PH_COLON_A = 17'h00040,
		PH_HOST    = 17'h00080,
		PH_COLON_B = 17'h00100,
		PH_TYP_I   = 17'h00200,
		PH_TYP_N   = 17'h00400,
		PH_TYP_S   = 17'h00800,
		PH_TYP_T   = 17'h01000,
		PH_TYP_R   = 17'h02000,
		PH_INST    = 17'h04000,
		PH_REJECT  = 17'h08000,
		PH_DONE    = 17'h10000
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              first;
	} in_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       host_char;
	} out_item_t;

endpackage

@@ hdl/iasc_if.sv @@
// Valid/ready channels carrying input bytes and per-byte verdicts.
interface iasc_in_if;
	logic                 valid;
	logic                 ready;
	iasc_pkg::in_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iasc_out_if;
	logic                 valid;
	logic                 ready;
	iasc_pkg::out_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/instrument_address_string_checker.sv @@
// Byte-serial checker for TCPIP[n]::host::INSTR[n] resource strings.
//
// chars carries one byte per beat (char_code, first); first restarts the
// check with that byte. verdicts returns one beat per input beat, in order:
// verdict (pending, accepted on the terminating NUL, rejected) and host_char.
// A rejection holds until the next beat with first set.
//
// An input beat reaches its verdict beat through the input register, then the
// result register. Throughput: one beat per cycle while verdicts is not stalled,
// set by the single pass through the pattern state machine and times-ten digit update.
//
// Reset clears both valid flags, the pattern state (first prefix letter) and
// the digit value; a stream without a first mark is checked from there.
// When verdicts stalls, the result register holds its beat and the input
// register can still take one more beat before chars.ready drops.
`include "assert_macros.svh"

module instrument_address_string_checker (
	input  logic              clk,
	input  logic              arst_n,
	iasc_in_if.sink           chars,
	iasc_out_if.source        verdicts
);

	logic                             valid_s1;
	iasc_pkg::in_item_t               item_s1;
	iasc_pkg::phase_t                 phase_q;
	logic [iasc_pkg::NUM_W-1:0]       num_q;
	logic                             out_valid_q;
	iasc_pkg::out_item_t              out_q;

	logic                             out_free;
	logic                             adv;
	iasc_pkg::phase_t                 cur_ph;
	iasc_pkg::phase_t                 nxt_ph;
	logic [iasc_pkg::NUM_W-1:0]       cur_num;
	logic [iasc_pkg::NUM_W-1:0]       nxt_num;
	logic [iasc_pkg::NUM_W-1:0]       num_x10;
	logic [iasc_pkg::CHAR_W-1:0]      c;
	logic [iasc_pkg::CHAR_W-1:0]      fold;
	logic                             is_digit;
	logic                             is_host;
	logic                             num_ok;
	logic                             host;
	logic [1:0]                       verdict;

	assign out_free     = !out_valid_q || verdicts.ready;
	assign adv          = valid_s1 && out_free;
	assign chars.ready  = !valid_s1 || out_free;
	assign verdicts.valid = out_valid_q;
	assign verdicts.data  = out_q;

	assign c        = item_s1.char_code;
	assign fold     = c | iasc_pkg::CASE_FOLD;
	assign cur_ph   = item_s1.first ? iasc_pkg::PH_PFX_T : phase_q;
	assign cur_num  = item_s1.first ? '0 : num_q;
	assign is_digit = (c >= iasc_pkg::CH_0) && (c <= iasc_pkg::CH_9);
	assign is_host  = is_digit || ((c >= iasc_pkg::CH_UA) && (c <= iasc_pkg::CH_UZ)) ||
		((c >= iasc_pkg::CH_LA) && (c <= iasc_pkg::CH_LZ)) ||
		(c == iasc_pkg::CH_DASH) || (c == iasc_pkg::CH_DOT);
	assign num_ok   = cur_num <= iasc_pkg::DIGIT_LIMIT;
	assign num_x10  = (cur_num << 3) + (cur_num << 1) +
		{{(iasc_pkg::NUM_W-4){1'b0}}, c[3:0]};

	always_comb begin
		nxt_ph  = iasc_pkg::PH_REJECT;
		nxt_num = cur_num;
		host    = 1'b0;
		unique case (cur_ph)
			iasc_pkg::PH_PFX_T: begin
				if (fold == iasc_pkg::CH_T) nxt_ph = iasc_pkg::PH_PFX_C;
			end
			iasc_pkg::PH_PFX_C: begin
				if (fold == iasc_pkg::CH_C) nxt_ph = iasc_pkg::PH_PFX_P1;
			end
			iasc_pkg::PH_PFX_P1: begin
				if (fold == iasc_pkg::CH_P) nxt_ph = iasc_pkg::PH_PFX_I;
			end
			iasc_pkg::PH_PFX_I: begin
				if (fold == iasc_pkg::CH_I) nxt_ph = iasc_pkg::PH_PFX_P2;
			end
			iasc_pkg::PH_PFX_P2: begin
				if (fold == iasc_pkg::CH_P) begin
					nxt_ph  = iasc_pkg::PH_BOARD;
					nxt_num = '0;
				end
			end
			iasc_pkg::PH_BOARD: begin
				if (is_digit) begin
					if (num_ok) begin
						nxt_ph  = iasc_pkg::PH_BOARD;
						nxt_num = num_x10;
					end
				end else if (c == iasc_pkg::CH_COLON) begin
					nxt_ph = iasc_pkg::PH_COLON_A;
				end
			end
			iasc_pkg::PH_COLON_A: begin
				if (c == iasc_pkg::CH_COLON) nxt_ph = iasc_pkg::PH_HOST;
			end
			iasc_pkg::PH_HOST: begin
				if (is_host) begin
					host   = 1'b1;
					nxt_ph = iasc_pkg::PH_HOST;
				end else if (c == iasc_pkg::CH_COLON) begin
					nxt_ph = iasc_pkg::PH_COLON_B;
				end
			end
			iasc_pkg::PH_COLON_B: begin
				if (c == iasc_pkg::CH_COLON) nxt_ph = iasc_pkg::PH_TYP_I;
			end
			iasc_pkg::PH_TYP_I: begin
				if (fold == iasc_pkg::CH_I) nxt_ph = iasc_pkg::PH_TYP_N;
			end
			iasc_pkg::PH_TYP_N: begin
				if (fold == iasc_pkg::CH_N) nxt_ph = iasc_pkg::PH_TYP_S;
			end
			iasc_pkg::PH_TYP_S: begin
				if (fold == iasc_pkg::CH_S) nxt_ph = iasc_pkg::PH_TYP_T;
			end
			iasc_pkg::PH_TYP_T: begin
				if (fold == iasc_pkg::CH_T) nxt_ph = iasc_pkg::PH_TYP_R;
			end
			iasc_pkg::PH_TYP_R: begin
				if (fold == iasc_pkg::CH_R) begin
					nxt_ph  = iasc_pkg::PH_INST;
					nxt_num = '0;
				end
			end
			iasc_pkg::PH_INST: begin
				if (is_digit) begin
					if (num_ok) begin
						nxt_ph  = iasc_pkg::PH_INST;
						nxt_num = num_x10;
					end
				end else if (c == iasc_pkg::CH_NUL) begin
					nxt_ph = iasc_pkg::PH_DONE;
				end
			end
			default: begin
				nxt_ph = iasc_pkg::PH_REJECT;
			end
		endcase
	end

	always_comb begin
		if (nxt_ph == iasc_pkg::PH_REJECT) begin
			verdict = iasc_pkg::V_REJECT;
		end else if (nxt_ph == iasc_pkg::PH_DONE) begin
			verdict = iasc_pkg::V_ACCEPT;
		end else begin
			verdict = iasc_pkg::V_PENDING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1 <= chars.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= iasc_pkg::PH_PFX_T;
			num_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			phase_q     <= nxt_ph;
			num_q       <= nxt_num;
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.verdict   <= verdict;
			out_q.host_char <= host;
		end
	end

	`AST_IMPL(a_accept_done, out_valid_q && (out_q.verdict == iasc_pkg::V_ACCEPT),
		phase_q == iasc_pkg::PH_DONE, "accept verdict without terminator state")
	`AST_IMPL(a_reject_state, out_valid_q && (out_q.verdict == iasc_pkg::V_REJECT),
		phase_q == iasc_pkg::PH_REJECT, "reject verdict without reject state")
	`AST_IMPL(a_host_pending, out_valid_q && out_q.host_char,
		(out_q.verdict == iasc_pkg::V_PENDING) && (phase_q == iasc_pkg::PH_HOST),
		"host character outside host field")
	`AST_NEXT(a_adv_result, adv, out_valid_q, "advanced beat produced no result")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the TCPIP instrument address string checker.
`timescale 1ns / 1ps

module tb_top;
	import iasc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BEATS = 1950;
	localparam int PACE_SPAN    = 390;
	localparam int HOLD_PERIOD  = 80;
	localparam int HOLD_LOW     = 60;

	typedef enum int {
		PACE_FREE,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH,
		PACE_BACKLOG
	} pace_t;

	typedef struct {
		in_item_t  beat;
		bit        typed;
		out_item_t verdict;
	} row_t;

	logic clk;
	logic arst_n;

	iasc_in_if  chars_if ();
	iasc_out_if verdicts_if ();

	instrument_address_string_checker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.verdicts (verdicts_if)
	);

	pace_t             pace = PACE_FREE;
	phase_t            pat_phase;
	logic [NUM_W-1:0]  digit_acc;
	out_item_t         verdict_q[$];
	logic [CHAR_W-1:0] str_q[$];
	row_t              dir_rows[$];
	int                errors = 0;
	int                beats_sent = 0;
	int                cycles = 0;
	int                n_accept = 0;
	int                n_reject = 0;
	int                n_host = 0;
	int                n_strings = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_dec(logic [CHAR_W-1:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	// false when the running value is already too large to take another digit
	function automatic bit take_digit(logic [CHAR_W-1:0] c);
		if (digit_acc > DIGIT_LIMIT)
			return 1'b0;
		digit_acc = digit_acc * 10 + NUM_W'(c - CH_0);
		return 1'b1;
	endfunction

	function automatic out_item_t predict_verdict(in_item_t beat);
		out_item_t         res;
		phase_t            nx;
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] folded;
		c = beat.char_code;
		folded = c | CASE_FOLD;
		res = '0;
		if (beat.first) begin
			pat_phase = PH_PFX_T;
			digit_acc = '0;
		end
		case (pat_phase)
			PH_PFX_T:  nx = (folded == CH_T) ? PH_PFX_C : PH_REJECT;
			PH_PFX_C:  nx = (folded == CH_C) ? PH_PFX_P1 : PH_REJECT;
			PH_PFX_P1: nx = (folded == CH_P) ? PH_PFX_I : PH_REJECT;
			PH_PFX_I:  nx = (folded == CH_I) ? PH_PFX_P2 : PH_REJECT;
			PH_PFX_P2: begin
				nx = (folded == CH_P) ? PH_BOARD : PH_REJECT;
				if (nx == PH_BOARD)
					digit_acc = '0;
			end
			PH_BOARD: begin
				if (is_dec(c))
					nx = take_digit(c) ? PH_BOARD : PH_REJECT;
				else
					nx = (c == CH_COLON) ? PH_COLON_A : PH_REJECT;
			end
			PH_COLON_A: nx = (c == CH_COLON) ? PH_HOST : PH_REJECT;
			PH_HOST: begin
				if (is_dec(c) || (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
						c == CH_DASH || c == CH_DOT) begin
					res.host_char = 1'b1;
					nx = PH_HOST;
				end else
					nx = (c == CH_COLON) ? PH_COLON_B : PH_REJECT;
			end
			PH_COLON_B: nx = (c == CH_COLON) ? PH_TYP_I : PH_REJECT;
			PH_TYP_I:   nx = (folded == CH_I) ? PH_TYP_N : PH_REJECT;
			PH_TYP_N:   nx = (folded == CH_N) ? PH_TYP_S : PH_REJECT;
			PH_TYP_S:   nx = (folded == CH_S) ? PH_TYP_T : PH_REJECT;
			PH_TYP_T:   nx = (folded == CH_T) ? PH_TYP_R : PH_REJECT;
			PH_TYP_R: begin
				nx = (folded == CH_R) ? PH_INST : PH_REJECT;
				if (nx == PH_INST)
					digit_acc = '0;
			end
			PH_INST: begin
				if (is_dec(c))
					nx = take_digit(c) ? PH_INST : PH_REJECT;
				else if (c == CH_NUL)
					nx = PH_DONE;
				else
					nx = PH_REJECT;
			end
			default: nx = PH_REJECT;
		endcase
		if (nx == PH_REJECT)
			res.verdict = V_REJECT;
		else if (nx == PH_DONE)
			res.verdict = V_ACCEPT;
		else
			res.verdict = V_PENDING;
		pat_phase = nx;
		return res;
	endfunction

	function automatic row_t dir_row(logic [CHAR_W-1:0] c, logic f, bit typed,
			logic [1:0] v, logic h);
		row_t r;
		r.beat = in_item_t'{char_code: c, first: f};
		r.typed = typed;
		r.verdict = out_item_t'{verdict: v, host_char: h};
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CH_0 + CHAR_W'($urandom_range(9));
	endfunction

	function automatic logic [CHAR_W-1:0] mixed_case(logic [CHAR_W-1:0] c);
		return $urandom_range(1) ? c : (c & ~CASE_FOLD);
	endfunction

	task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t typed_v);
		int gap_pct;
		gap_pct = (pace == PACE_SEND_GAPS) ? 55 : (pace == PACE_BOTH) ? 7 : 0;
		while ($urandom_range(99) < gap_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.data  <= beat;
		@(posedge clk);
		while (chars_if.ready !== 1'b1)
			@(posedge clk);
		if (typed) begin
			void'(predict_verdict(beat));
			verdict_q.push_back(typed_v);
		end else
			verdict_q.push_back(predict_verdict(beat));
		beats_sent++;
	endtask

	task automatic add_digit_field();
		string num;
		int    i;
		case ($urandom_range(9))
			0, 1, 2: ;
			3, 4, 5: repeat ($urandom_range(4, 1)) str_q.push_back(rand_digit());
			6, 7: begin
				// right at the overflow threshold or one above it
				num = $sformatf("%0d", DIGIT_LIMIT + $urandom_range(1));
				for (i = 0; i < num.len(); i++)
					str_q.push_back(num[i]);
				repeat ($urandom_range(2, 1)) str_q.push_back(rand_digit());
			end
			8: repeat ($urandom_range(12, 10)) str_q.push_back(rand_digit());
			default: begin
				repeat ($urandom_range(12, 1)) str_q.push_back(CH_0);
				repeat ($urandom_range(3)) str_q.push_back(rand_digit());
			end
		endcase
	endtask

	task automatic send_random_string();
		logic [CHAR_W-1:0] word [10];
		int                shape;
		int                cut;
		int                stray;
		int                i;
		bit                mark;
		str_q.delete();
		shape = $urandom_range(99);
		if (shape < 12) begin
			repeat ($urandom_range(12, 1)) str_q.push_back(CHAR_W'($urandom));
		end else begin
			word = '{CH_T, CH_C, CH_P, CH_I, CH_P, CH_I, CH_N, CH_S, CH_T, CH_R};
			for (i = 0; i < 5; i++)
				str_q.push_back(mixed_case(word[i]));
			add_digit_field();
			str_q.push_back(CH_COLON);
			str_q.push_back(CH_COLON);
			repeat (($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1)) begin
				case ($urandom_range(3))
					0: str_q.push_back(CH_UA + CHAR_W'($urandom_range(25)));
					1: str_q.push_back(CH_LA + CHAR_W'($urandom_range(25)));
					2: str_q.push_back(rand_digit());
					default: str_q.push_back($urandom_range(1) ? CH_DASH : CH_DOT);
				endcase
			end
			str_q.push_back(CH_COLON);
			str_q.push_back(CH_COLON);
			for (i = 5; i < 10; i++)
				str_q.push_back(mixed_case(word[i]));
			add_digit_field();
			str_q.push_back(CH_NUL);
			// broken strings: one bad byte, cut short, or bytes past the NUL
			if (shape >= 75) begin
				case ($urandom_range(2))
					0: str_q[$urandom_range(str_q.size() - 1)] = CHAR_W'($urandom);
					1: begin
						cut = $urandom_range(str_q.size() - 1, 1);
						while (str_q.size() > cut)
							void'(str_q.pop_back());
					end
					default: repeat ($urandom_range(3, 1)) str_q.push_back(CHAR_W'($urandom));
				endcase
			end
		end
		mark = ($urandom_range(19) != 0);
		stray = ($urandom_range(19) == 0) ? $urandom_range(str_q.size() - 1) : -1;
		n_strings++;
		for (i = 0; i < str_q.size(); i++)
			send_beat(in_item_t'{char_code: str_q[i], first: (i == 0) ? mark : (i == stray)},
				1'b0, '0);
	endtask

	initial begin : receiver
		int        stall_pct;
		int        backlog;
		out_item_t want;
		backlog = 0;
		verdicts_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (verdicts_if.valid === 1'b1 && verdicts_if.ready === 1'b1) begin
				if (verdict_q.size() == 0) begin
					errors++;
					$error("verdict beat with no byte outstanding");
				end else begin
					want = verdict_q.pop_front();
					if (verdicts_if.data.verdict !== want.verdict) begin
						errors++;
						$error("verdict: expected %0d, got %0d", want.verdict,
							verdicts_if.data.verdict);
					end
					if (verdicts_if.data.host_char !== want.host_char) begin
						errors++;
						$error("host_char: expected %0d, got %0d", want.host_char,
							verdicts_if.data.host_char);
					end
					n_accept += (want.verdict == V_ACCEPT);
					n_reject += (want.verdict == V_REJECT);
					n_host += want.host_char;
				end
			end
			stall_pct = (pace == PACE_RECV_STALLS) ? 55 : (pace == PACE_BOTH) ? 7 : 0;
			if (pace == PACE_BACKLOG) begin
				// long hold-off so the input side backs up
				backlog++;
				verdicts_if.ready <= (backlog % HOLD_PERIOD) >= HOLD_LOW;
			end else
				verdicts_if.ready <= $urandom_range(99) >= stall_pct;
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d verdicts outstanding", cycles, verdict_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int i;
		arst_n         <= 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.data  <= '0;
		pat_phase = PH_PFX_T;
		digit_acc = '0;

		// no first mark after reset, mixed case, board and instance digits
		dir_rows.push_back(dir_row(CH_T & ~CASE_FOLD, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_C, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_P & ~CASE_FOLD, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_I & ~CASE_FOLD, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_P, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_0, 1'b0, 1'b0, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_9, 1'b0, 1'b0, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_COLON, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_COLON, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_UA, 1'b0, 1'b1, V_PENDING, 1'b1));
		dir_rows.push_back(dir_row(CH_DASH, 1'b0, 1'b1, V_PENDING, 1'b1));
		dir_rows.push_back(dir_row(CH_9, 1'b0, 1'b1, V_PENDING, 1'b1));
		dir_rows.push_back(dir_row(CH_DOT, 1'b0, 1'b1, V_PENDING, 1'b1));
		dir_rows.push_back(dir_row(CH_LZ, 1'b0, 1'b1, V_PENDING, 1'b1));
		dir_rows.push_back(dir_row(CH_COLON, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_COLON, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_I, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_N & ~CASE_FOLD, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_S, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_T & ~CASE_FOLD, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_R, 1'b0, 1'b1, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_9, 1'b0, 1'b0, V_PENDING, 1'b0));
		dir_rows.push_back(dir_row(CH_NUL, 1'b0, 1'b1, V_ACCEPT, 1'b0));
		// past the terminator, NUL as first byte, rejection holds, restart
		dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, V_REJECT, 1'b0));
		dir_rows.push_back(dir_row(CH_NUL, 1'b1, 1'b1, V_REJECT, 1'b0));
		dir_rows.push_back(dir_row(CH_T, 1'b0, 1'b1, V_REJECT, 1'b0));
		dir_rows.push_back(dir_row(CH_T, 1'b1, 1'b1, V_PENDING, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < dir_rows.size(); i++)
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].verdict);

		while (beats_sent < dir_rows.size() + RANDOM_BEATS) begin
			pace = pace_t'(((beats_sent - dir_rows.size()) / PACE_SPAN) % 5);
			send_random_string();
		end
		chars_if.valid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d strings over five pacing phases incl. a long hold-off.",
			beats_sent, n_strings);
		$display("Verdicts seen: %0d accepted, %0d rejected, %0d host-name bytes flagged.",
			n_accept, n_reject, n_host);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/iasc_pkg.sv
hdl/iasc_if.sv
hdl/instrument_address_string_checker.sv
tb/tb_top.sv
